// ===== hdl/frame_time_window_stats_defines.svh =====
// Assertion helpers shared by the frame time statistics block.
`ifndef FRAME_TIME_WINDOW_STATS_DEFINES_SVH
`define FRAME_TIME_WINDOW_STATS_DEFINES_SVH

// Same-cycle implication.
`define FTWS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define FTWS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ftws_pkg.sv =====
package ftws_pkg;

   localparam int AVG_W     = 24;
   localparam int RATE_W    = 30;
   localparam int CNT_OUT_W = 8;
   localparam int RSP_W     = 112;

   localparam logic [RATE_W-1:0] RATE_FULL = 30'd1000000000;

   // req_tuser op codes
   localparam logic OP_RESTART = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } ftws_div_stat_type;

endpackage

// ===== hdl/ftws_ram.sv =====
module ftws_ram #(
   parameter int WIDTH  = 24,
   parameter int DEPTH  = 128,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;
   logic [WIDTH-1:0] rd_data_in;

   assign rd_data_in = mem_ff[rd_addr];
   assign rd_data    = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= rd_data_in;
   end

endmodule

// ===== hdl/ftws_div.sv =====
`include "frame_time_window_stats_defines.svh"

// Restoring divider, one quotient bit per cycle.
module ftws_div import ftws_pkg::*; #(
   parameter int DVD_W = 32,
   parameter int DIV_W = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DVD_W-1:0]  dividend,
   input  logic [DIV_W-1:0]  divisor,
   output logic [DVD_W-1:0]  quotient,
   output ftws_div_stat_type stat
);

   localparam int CW = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dsr_ff, dsr_in;

   logic [DIV_W:0]   trial;
   logic [DIV_W:0]   trial_sub;
   logic             fits;

   assign trial     = {rem_ff, quo_ff[DVD_W-1]};
   assign trial_sub = trial - {1'b0, dsr_ff};
   assign fits      = (trial >= {1'b0, dsr_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CW'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   `FTWS_ASSERT_IMPL(a_no_start_busy, clock, reset, start, !busy_ff, "divider restarted while busy")
   `FTWS_ASSERT_NEXT(a_done_pulse, clock, reset, done_ff, !done_ff, "divider done held over two cycles")
   `FTWS_ASSERT_IMPL(a_rem_below, clock, reset, done_ff && (dsr_ff != '0), rem_ff < dsr_ff, "divider remainder not below divisor")

endmodule

// ===== hdl/frame_time_window_stats.sv =====
// Frame time window statistics. Each req beat carries a free-running microsecond
// timestamp (req_tdata) and an op (req_tuser: 0 = frame tick, 1 = restart). A tick
// turns the wrapped difference from the previous timestamp, saturated to TIME_BITS,
// into a frame time that replaces the oldest of SAMPLES ring entries, and returns one
// rsp beat with the truncated window average, the rate in milli-frames per second
// (1e9 / average, 1e9 when the average is zero), the window min and max, and the
// number of valid samples. A restart clears the history, keeps the timestamp and
// returns all zeros. One beat is handled at a time. A tick runs the bit-serial divider
// once for the average and once for the rate, the rate divide being skipped when the
// average is zero, and then the min/max scan, which reads the ring RAM one entry per
// cycle. The rsp beat appears in the same cycle as the block is ready again. A
// finished result sits in the rsp register, so the next req beat is taken while it
// waits. The ring needs no clearing pass after reset or restart: the fill count masks
// entries not yet written.
`include "frame_time_window_stats_defines.svh"

module frame_time_window_stats import ftws_pkg::*; #(
   parameter int SAMPLES   = 128,
   parameter int TIME_BITS = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [31:0]      req_tdata,   // timestamp_us[31:0]
   input  logic             req_tuser,   // op[0]
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // avg_frame_us[23:0], rate_milli_fps[53:24],
                                         // min_frame_us[77:54], max_frame_us[101:78],
                                         // valid_count[109:102], zero pad[111:110]
);

   localparam int CNT_W = $clog2(SAMPLES + 1);
   localparam int AW    = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam int SUM_W = TIME_BITS + CNT_W;
   localparam int DVD_W = (SUM_W > RATE_W) ? SUM_W : RATE_W;
   localparam int DIV_W = (TIME_BITS > CNT_W) ? TIME_BITS : CNT_W;

   localparam logic [32:0]      MAX_FRAME_X = (33'd1 << TIME_BITS) - 33'd1;
   localparam logic [31:0]      MAX_FRAME   = MAX_FRAME_X[31:0];
   localparam logic [CNT_W-1:0] CNT_FULL    = CNT_W'(SAMPLES);
   localparam logic [AW-1:0]    SLOT_LAST   = AW'(SAMPLES - 1);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_UPD     = 3'd1;
   localparam logic [2:0] S_DIV1_GO = 3'd2;
   localparam logic [2:0] S_DIV1    = 3'd3;
   localparam logic [2:0] S_DIV2_GO = 3'd4;
   localparam logic [2:0] S_DIV2    = 3'd5;
   localparam logic [2:0] S_SCAN    = 3'd6;
   localparam logic [2:0] S_DONE    = 3'd7;

   // control state
   logic [2:0]           state_ff, state_in;
   logic [AW-1:0]        slot_ff, slot_in;
   logic [CNT_W-1:0]     filled_ff, filled_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [31:0]          stamp_ff, stamp_in;
   logic [CNT_W-1:0]     scan_ff, scan_in;
   logic                 scan_vld_ff, scan_vld_in;
   logic                 scan_first_ff, scan_first_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;

   // payload
   logic [TIME_BITS-1:0] delta_ff, delta_in;
   logic [TIME_BITS-1:0] avg_ff, avg_in;
   logic [RATE_W-1:0]    rate_ff, rate_in;
   logic [TIME_BITS-1:0] min_ff, min_in;
   logic [TIME_BITS-1:0] max_ff, max_in;
   logic [RSP_W-1:0]     rsp_data_ff, rsp_data_in;

   logic [31:0]          diff;
   logic [TIME_BITS-1:0] old_entry;
   logic                 scan_issue;

   // ring RAM
   logic                 ram_wr_en;
   logic [AW-1:0]        ram_rd_addr;
   logic [TIME_BITS-1:0] ram_rd_data;

   // shared divider
   logic                 div_start;
   logic [DVD_W-1:0]     div_dividend;
   logic [DIV_W-1:0]     div_divisor;
   logic [DVD_W-1:0]     div_quotient;
   ftws_div_stat_type    div_stat;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign diff       = req_tdata - stamp_ff;
   assign ram_wr_en  = (state_ff == S_UPD);
   // outside the scan the read port sits on the write slot, so the entry about to be
   // replaced is in the RAM output register in the cycle after the req beat
   assign ram_rd_addr = (state_ff == S_SCAN) ? scan_ff[AW-1:0] : slot_ff;
   // an entry only counts once the window is full; before that it was never written
   assign old_entry  = (filled_ff == CNT_FULL) ? ram_rd_data : '0;
   assign scan_issue = (scan_ff != filled_ff);

   assign div_start    = (state_ff == S_DIV1_GO) || (state_ff == S_DIV2_GO);
   assign div_dividend = (state_ff == S_DIV1_GO) ? DVD_W'(sum_ff) : DVD_W'(RATE_FULL);
   assign div_divisor  = (state_ff == S_DIV1_GO) ? DIV_W'(filled_ff) : DIV_W'(avg_ff);

   always_comb begin
      state_in      = state_ff;
      slot_in       = slot_ff;
      filled_in     = filled_ff;
      sum_in        = sum_ff;
      stamp_in      = stamp_ff;
      scan_in       = scan_ff;
      scan_vld_in   = 1'b0;
      scan_first_in = scan_first_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      delta_in      = delta_ff;
      avg_in        = avg_ff;
      rate_in       = rate_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      rsp_data_in   = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               stamp_in = req_tdata;
               if (req_tuser == OP_RESTART) begin
                  slot_in   = '0;
                  filled_in = '0;
                  sum_in    = '0;
                  avg_in    = '0;
                  rate_in   = '0;
                  min_in    = '0;
                  max_in    = '0;
                  state_in  = S_DONE;
               end else begin
                  // long gaps saturate
                  delta_in = (diff > MAX_FRAME) ? MAX_FRAME[TIME_BITS-1:0]
                                                : diff[TIME_BITS-1:0];
                  state_in = S_UPD;
               end
            end
         end
         S_UPD: begin
            sum_in   = sum_ff - SUM_W'(old_entry) + SUM_W'(delta_ff);
            slot_in  = (slot_ff == SLOT_LAST) ? '0 : slot_ff + AW'(1);
            if (filled_ff != CNT_FULL) begin
               filled_in = filled_ff + CNT_W'(1);
            end
            state_in = S_DIV1_GO;
         end
         S_DIV1_GO: begin
            state_in = S_DIV1;
         end
         S_DIV1: begin
            if (div_stat.done) begin
               avg_in = div_quotient[TIME_BITS-1:0];
               if (div_quotient == '0) begin
                  rate_in       = RATE_FULL;
                  scan_in       = '0;
                  scan_first_in = 1'b1;
                  state_in      = S_SCAN;
               end else begin
                  state_in = S_DIV2_GO;
               end
            end
         end
         S_DIV2_GO: begin
            state_in = S_DIV2;
         end
         S_DIV2: begin
            if (div_stat.done) begin
               rate_in       = div_quotient[RATE_W-1:0];
               scan_in       = '0;
               scan_first_in = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            // one read issued per cycle, its data compared in the next cycle
            if (scan_issue) begin
               scan_in     = scan_ff + CNT_W'(1);
               scan_vld_in = 1'b1;
            end
            if (scan_vld_ff) begin
               scan_first_in = 1'b0;
               if (scan_first_ff || (ram_rd_data < min_ff)) begin
                  min_in = ram_rd_data;
               end
               if (scan_first_ff || (ram_rd_data > max_ff)) begin
                  max_in = ram_rd_data;
               end
            end
            if (!scan_issue && !scan_vld_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_data_in   = {2'b00, CNT_OUT_W'(filled_ff), AVG_W'(max_ff),
                                AVG_W'(min_ff), rate_ff, AVG_W'(avg_ff)};
               rsp_tvalid_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slot_ff       <= '0;
         filled_ff     <= '0;
         sum_ff        <= '0;
         stamp_ff      <= '0;
         scan_ff       <= '0;
         scan_vld_ff   <= 1'b0;
         scan_first_ff <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_ff       <= slot_in;
         filled_ff     <= filled_in;
         sum_ff        <= sum_in;
         stamp_ff      <= stamp_in;
         scan_ff       <= scan_in;
         scan_vld_ff   <= scan_vld_in;
         scan_first_ff <= scan_first_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      delta_ff    <= delta_in;
      avg_ff      <= avg_in;
      rate_ff     <= rate_in;
      min_ff      <= min_in;
      max_ff      <= max_in;
      rsp_data_ff <= rsp_data_in;
   end

   ftws_ram #(
      .WIDTH  (TIME_BITS),
      .DEPTH  (SAMPLES),
      .ADDR_W (AW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (delta_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ftws_div #(
      .DVD_W (DVD_W),
      .DIV_W (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .stat     (div_stat)
   );

   `FTWS_ASSERT_NEXT(a_busy_after_beat, clock, reset, req_tvalid && req_tready, !req_tready, "req taken twice in a row")
   `FTWS_ASSERT_IMPL(a_fill_bound, clock, reset, 1'b1, filled_ff <= CNT_FULL, "fill count past window size")
   `FTWS_ASSERT_IMPL(a_idle_div_quiet, clock, reset, state_ff == S_IDLE, !div_stat.busy, "divider busy while idle")
   `FTWS_ASSERT_IMPL(a_avg_in_range, clock, reset, (state_ff == S_DONE) && (filled_ff != '0), (min_ff <= avg_ff) && (avg_ff <= max_ff), "average outside window min/max")

endmodule
